/* src/ptsoc_pkg.sv */
package ptsoc_pkg;

  localparam int RAW_W     = 24;
  localparam int CAL_W     = 16;
  localparam int TEMP_W    = 19;
  localparam int PRES_W    = 23;
  localparam int CFG_IDX_W = 3;

  localparam int DT_W   = 25;
  localparam int PT_W   = 42;
  localparam int DT2_W  = 48;
  localparam int DEV_W  = 18;
  localparam int TI_W   = 17;
  localparam int DEV2_W = 34;
  localparam int SENS_W = 38;
  localparam int OFF_W  = 38;
  localparam int PL_W   = 42;
  localparam int PH_W   = 45;
  localparam int PROD_W = 63;
  localparam int T_W    = 42;
  localparam int A_W    = 43;
  localparam int MAG_W  = 32;
  localparam int PRD_W  = 2 * MAG_W;
  localparam int QUO_W  = PRD_W - 35;

  localparam int TEMP_SHIFT = 23;
  localparam int SENS_SHIFT = 8;
  localparam int OFF_SHIFT  = 7;
  localparam int PROD_SHIFT = 21;
  localparam int PRES_SHIFT = 13;
  localparam int DIV10_SHIFT = 35;

  localparam int LATENCY = 12;

  localparam logic signed [TEMP_W:0] TEMP_REF    = 20'sd2000;
  localparam logic [MAG_W-1:0]       DIV10_MAGIC = 32'hCCCC_CCCD;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_C1 = 3'd0,
    REG_C2 = 3'd1,
    REG_C3 = 3'd2,
    REG_C4 = 3'd3,
    REG_C5 = 3'd4,
    REG_C6 = 3'd5
  } ptsoc_reg_t;

  typedef struct packed {
    logic             vld;
    logic             neg;
    logic [MAG_W-1:0] mag;
  } ptsoc_div_beat_t;

endpackage

/* src/ptsoc_div10.sv */
module ptsoc_div10 import ptsoc_pkg::*; (
  input  logic                     clk,
  input  logic                     rst_n,
  input  ptsoc_div_beat_t          beat_i,
  output logic                     vld_o,
  output logic signed [PRES_W-1:0] quo_o
);

  logic [PRD_W-1:0]        prd_r, prd_nxt;
  logic                    neg_r;
  logic                    vld1_r, vld2_r;
  logic [QUO_W-1:0]        q;
  logic [QUO_W-1:0]        qs;
  logic signed [PRES_W-1:0] quo_r, quo_nxt;

  always_comb begin
    prd_nxt = PRD_W'(beat_i.mag) * PRD_W'(DIV10_MAGIC);
  end

  always_comb begin
    q       = prd_r[PRD_W-1:DIV10_SHIFT];
    qs      = neg_r ? (~q + QUO_W'(1)) : q;
    quo_nxt = qs[PRES_W-1:0];
  end

  always_ff @(posedge clk) begin
    prd_r <= prd_nxt;
    neg_r <= beat_i.neg;
    quo_r <= quo_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld1_r <= 1'b0;
      vld2_r <= 1'b0;
    end else begin
      vld1_r <= beat_i.vld;
      vld2_r <= vld1_r;
    end
  end

  assign vld_o = vld2_r;
  assign quo_o = quo_r;

endmodule

/* src/pressure_temp_second_order_comp.sv */
// Second-order compensation of a piezoresistive pressure sensor.
// Input: pulse start with in_raw_pressure (D1) and in_raw_temperature (D2)
// present; a beat is taken at every rising edge where start is high and
// busy is low. busy stays low, so a new beat may enter every cycle.
// Output: out_strobe is high for one cycle with out_temperature_centi
// (0.01 degC) and out_pressure_mbar, both two's complement. The receiver
// cannot stall; every beat is delivered in order.
// Throughput one beat per cycle, set by the 12-stage pipeline with at most
// one multiplier level per stage and a reciprocal multiply for the /10.
// Calibration words C1..C6 are loaded through cfg_we/cfg_index/cfg_wdata,
// index 0 to 5; other indexes are ignored. Load them only while no beat
// is in flight.
// Reset (rst_n low, synchronous) clears the calibration words to zero and
// drops every beat in flight.
module pressure_temp_second_order_comp import ptsoc_pkg::*; (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     start,
  output logic                     busy,
  input  logic [RAW_W-1:0]         in_raw_pressure,
  input  logic [RAW_W-1:0]         in_raw_temperature,
  output logic                     out_strobe,
  output logic signed [TEMP_W-1:0] out_temperature_centi,
  output logic signed [PRES_W-1:0] out_pressure_mbar,
  input  logic                     cfg_we,
  input  logic [CFG_IDX_W-1:0]     cfg_index,
  input  logic [CAL_W-1:0]         cfg_wdata
);

  logic [CAL_W-1:0] c1_r, c2_r, c3_r, c4_r, c5_r, c6_r;
  logic [9:0]       vld_r;

  logic signed [DT_W-1:0]   dt_r, dt_nxt;
  logic [RAW_W-1:0]         d1_r [5];
  logic signed [PT_W-1:0]   pt_r, pt_nxt, ps_r, ps_nxt, po_r, po_nxt;
  logic signed [2*DT_W-1:0] sq_full;
  logic [DT2_W-1:0]         dt2_r, dt2_nxt;

  logic signed [PT_W-1:0]   pt_b, ps_b, po_b, dev_full, ps_q, po_q;
  logic [DT2_W+1:0]         sq3;
  logic signed [DEV_W-1:0]  dev_r, dev_nxt;
  logic signed [SENS_W-1:0] sens1_r, sens1_nxt, sens1_d_r;
  logic signed [OFF_W-1:0]  off1_r, off1_nxt, off1_d_r;
  logic [TI_W-1:0]          ti_r, ti_nxt;
  logic                     low_r, low_nxt, low_d_r;

  logic signed [2*DEV_W-1:0] dsq;
  logic [DEV2_W-1:0]         dev2_r, dev2_nxt;
  logic signed [TEMP_W:0]    tsum;
  logic signed [TEMP_W-1:0]  tmp_r [9];
  logic signed [TEMP_W-1:0]  tmp_nxt;

  logic [DEV2_W+1:0]        s3;
  logic [DEV2_W+2:0]        s5;
  logic [DEV2_W:0]          offi;
  logic [DEV2_W-1:0]        sensi;
  logic signed [SENS_W-1:0] sens2_r, sens2_nxt;
  logic signed [OFF_W-1:0]  off2_r [4];
  logic signed [OFF_W-1:0]  off2_nxt;

  logic [PL_W-1:0]          pl_r, pl_nxt;
  logic signed [PH_W-1:0]   ph_r, ph_nxt;
  logic signed [PROD_W-1:0] prod_r, prod_nxt, prod_b, t_full;
  logic signed [T_W-1:0]    t_r, t_nxt;
  logic signed [A_W-1:0]    a_r, a_nxt;
  logic [A_W-1:0]           a_abs;
  logic                     neg_r, neg_nxt;
  logic [MAG_W-1:0]         mag_r, mag_nxt;

  ptsoc_div_beat_t div_beat;

  assign busy = 1'b0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      c1_r <= '0;
      c2_r <= '0;
      c3_r <= '0;
      c4_r <= '0;
      c5_r <= '0;
      c6_r <= '0;
    end else if (cfg_we) begin
      case (ptsoc_reg_t'(cfg_index))
        REG_C1:  c1_r <= cfg_wdata;
        REG_C2:  c2_r <= cfg_wdata;
        REG_C3:  c3_r <= cfg_wdata;
        REG_C4:  c4_r <= cfg_wdata;
        REG_C5:  c5_r <= cfg_wdata;
        REG_C6:  c6_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= {vld_r[8:0], start & ~busy};
    end
  end

  // stage 0: dT
  always_comb begin
    dt_nxt = $signed({1'b0, in_raw_temperature}) - $signed({1'b0, c5_r, 8'd0});
  end

  // stage 1: products of dT
  always_comb begin
    pt_nxt  = dt_r * $signed({1'b0, c6_r});
    ps_nxt  = dt_r * $signed({1'b0, c3_r});
    po_nxt  = dt_r * $signed({1'b0, c4_r});
    sq_full = dt_r * dt_r;
    dt2_nxt = sq_full[DT2_W-1:0];
  end

  // stage 2: first-order terms, truncating shifts
  always_comb begin
    pt_b      = pt_r + $signed({{(PT_W-TEMP_SHIFT){1'b0}}, {TEMP_SHIFT{pt_r[PT_W-1]}}});
    dev_full  = pt_b >>> TEMP_SHIFT;
    dev_nxt   = dev_full[DEV_W-1:0];
    ps_b      = ps_r + $signed({{(PT_W-SENS_SHIFT){1'b0}}, {SENS_SHIFT{ps_r[PT_W-1]}}});
    ps_q      = ps_b >>> SENS_SHIFT;
    po_b      = po_r + $signed({{(PT_W-OFF_SHIFT){1'b0}}, {OFF_SHIFT{po_r[PT_W-1]}}});
    po_q      = po_b >>> OFF_SHIFT;
    sens1_nxt = $signed({7'd0, c1_r, 15'd0}) + ps_q[SENS_W-1:0];
    off1_nxt  = $signed({6'd0, c2_r, 16'd0}) + po_q[OFF_W-1:0];
    low_nxt   = dev_nxt[DEV_W-1];
    sq3       = {2'b0, dt2_r} + {1'b0, dt2_r, 1'b0};
    ti_nxt    = low_nxt ? sq3[DT2_W+1:33] : {5'd0, dt2_r[DT2_W-1:36]};
  end

  // stage 3: squared deviation, compensated temperature
  always_comb begin
    dsq      = dev_r * dev_r;
    dev2_nxt = dsq[DEV2_W-1:0];
    tsum     = TEMP_REF + {{2{dev_r[DEV_W-1]}}, dev_r} - {3'd0, ti_r};
    tmp_nxt  = tsum[TEMP_W-1:0];
  end

  // stage 4: second-order offset and sensitivity
  always_comb begin
    s3        = {2'b0, dev2_r} + {1'b0, dev2_r, 1'b0};
    s5        = {3'b0, dev2_r} + {1'b0, dev2_r, 2'b0};
    offi      = low_d_r ? s3[DEV2_W+1:1] : {5'd0, dev2_r[DEV2_W-1:4]};
    sensi     = low_d_r ? s5[DEV2_W+2:3] : '0;
    sens2_nxt = sens1_d_r - $signed({4'd0, sensi});
    off2_nxt  = off1_d_r - $signed({3'd0, offi});
  end

  // stage 5: D1 * SENS2 as two partial products
  always_comb begin
    pl_nxt = PL_W'(d1_r[4]) * PL_W'(sens2_r[17:0]);
    ph_nxt = $signed({1'b0, d1_r[4]}) * $signed(sens2_r[SENS_W-1:18]);
  end

  // stage 6: combine partial products
  always_comb begin
    prod_nxt = $signed({ph_r, 18'd0}) + $signed({21'd0, pl_r});
  end

  // stage 7: truncating divide by 2^21
  always_comb begin
    prod_b = prod_r + $signed({{(PROD_W-PROD_SHIFT){1'b0}}, {PROD_SHIFT{prod_r[PROD_W-1]}}});
    t_full = prod_b >>> PROD_SHIFT;
    t_nxt  = t_full[T_W-1:0];
  end

  // stage 8: subtract OFF2
  always_comb begin
    a_nxt = {t_r[T_W-1], t_r} - {{(A_W-OFF_W){off2_r[3][OFF_W-1]}}, off2_r[3]};
  end

  // stage 9: sign and magnitude, truncating divide by 2^13
  always_comb begin
    neg_nxt = a_r[A_W-1];
    a_abs   = neg_nxt ? (~a_r + A_W'(1)) : a_r;
    mag_nxt = {{(MAG_W-(A_W-PRES_SHIFT)){1'b0}}, a_abs[A_W-1:PRES_SHIFT]};
  end

  always_ff @(posedge clk) begin
    dt_r      <= dt_nxt;
    d1_r[0]   <= in_raw_pressure;
    for (int i = 1; i < 5; i++) begin
      d1_r[i] <= d1_r[i-1];
    end
    pt_r      <= pt_nxt;
    ps_r      <= ps_nxt;
    po_r      <= po_nxt;
    dt2_r     <= dt2_nxt;
    dev_r     <= dev_nxt;
    sens1_r   <= sens1_nxt;
    off1_r    <= off1_nxt;
    ti_r      <= ti_nxt;
    low_r     <= low_nxt;
    dev2_r    <= dev2_nxt;
    sens1_d_r <= sens1_r;
    off1_d_r  <= off1_r;
    low_d_r   <= low_r;
    tmp_r[0]  <= tmp_nxt;
    for (int i = 1; i < 9; i++) begin
      tmp_r[i] <= tmp_r[i-1];
    end
    sens2_r   <= sens2_nxt;
    off2_r[0] <= off2_nxt;
    for (int i = 1; i < 4; i++) begin
      off2_r[i] <= off2_r[i-1];
    end
    pl_r      <= pl_nxt;
    ph_r      <= ph_nxt;
    prod_r    <= prod_nxt;
    t_r       <= t_nxt;
    a_r       <= a_nxt;
    neg_r     <= neg_nxt;
    mag_r     <= mag_nxt;
  end

  assign div_beat = '{vld: vld_r[9], neg: neg_r, mag: mag_r};

  ptsoc_div10 u_div10 (
    .clk    (clk),
    .rst_n  (rst_n),
    .beat_i (div_beat),
    .vld_o  (out_strobe),
    .quo_o  (out_pressure_mbar)
  );

  assign out_temperature_centi = tmp_r[8];

endmodule

/* src/ptsoc_checker.sv */
module ptsoc_props import ptsoc_pkg::*; (
  input logic                     clk,
  input logic                     rst_n,
  input logic                     start,
  input logic                     busy,
  input logic [RAW_W-1:0]         in_raw_pressure,
  input logic [RAW_W-1:0]         in_raw_temperature,
  input logic                     out_strobe,
  input logic signed [TEMP_W-1:0] out_temperature_centi,
  input logic signed [PRES_W-1:0] out_pressure_mbar,
  input logic                     cfg_we,
  input logic [CFG_IDX_W-1:0]     cfg_index,
  input logic [CAL_W-1:0]         cfg_wdata
);

  logic acc;

  assign acc = start && !busy;

  a_beat_delivered: assert property (@(posedge clk) disable iff (!rst_n)
    acc |-> ##LATENCY out_strobe)
    else $error("accepted beat not delivered after fixed latency");

  a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> $past(acc && rst_n, LATENCY))
    else $error("result strobe without a matching accepted beat");

  a_never_busy: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) |-> !busy)
    else $error("busy raised on a fully pipelined block");

endmodule

bind pressure_temp_second_order_comp ptsoc_props u_ptsoc_props (.*);

/* test/ptsoc_checker.sv */
`timescale 1ns / 100ps
module ptsoc_checker import ptsoc_pkg::*; (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     start,
  input  logic                     busy,
  input  logic [RAW_W-1:0]         in_raw_pressure,
  input  logic [RAW_W-1:0]         in_raw_temperature,
  input  logic                     out_strobe,
  input  logic signed [TEMP_W-1:0] out_temperature_centi,
  input  logic signed [PRES_W-1:0] out_pressure_mbar,
  input  logic                     cfg_we,
  input  logic [CFG_IDX_W-1:0]     cfg_index,
  input  logic [CAL_W-1:0]         cfg_wdata,
  output int                       fail_count,
  output int                       pending,
  output int                       checked,
  output int                       cold_count
);

  localparam int NUM_CAL = REG_C6 + 1;

  typedef struct packed {
    logic                     cold;
    logic signed [TEMP_W-1:0] temp;
    logic signed [PRES_W-1:0] pres;
  } reading_t;

  logic [CAL_W-1:0] cal [NUM_CAL];
  reading_t         reading_q [$];

  function automatic reading_t compensate(input logic [RAW_W-1:0] d1_raw,
                                          input logic [RAW_W-1:0] d2_raw);
    longint d1, d2, k1, k2, k3, k4, k5, k6;
    longint dt, temp, off, sens, dev, ti, offi, sensi, pres;
    reading_t r;
    d1 = d1_raw;
    d2 = d2_raw;
    k1 = cal[REG_C1];
    k2 = cal[REG_C2];
    k3 = cal[REG_C3];
    k4 = cal[REG_C4];
    k5 = cal[REG_C5];
    k6 = cal[REG_C6];
    dt   = d2 - k5 * 256;
    sens = k1 * 32768 + (k3 * dt) / 256;
    off  = k2 * 65536 + (k4 * dt) / 128;
    temp = 2000 + (dt * k6) / 8388608;
    dev  = temp - 2000;
    r.cold = (temp < 2000);
    if (r.cold) begin
      ti    = (3 * dt * dt) / 64'sd8589934592;
      offi  = (3 * dev * dev) / 2;
      sensi = (5 * dev * dev) / 8;
    end else begin
      ti    = (2 * dt * dt) / 64'sd137438953472;
      offi  = (dev * dev) / 16;
      sensi = 0;
    end
    off  = off - offi;
    sens = sens - sensi;
    temp = temp - ti;
    pres = (((d1 * sens) / 2097152 - off) / 8192) / 10;
    r.temp = temp[TEMP_W-1:0];
    r.pres = pres[PRES_W-1:0];
    return r;
  endfunction

  always @(posedge clk) begin
    reading_t want;
    if (!rst_n) begin
      reading_q.delete();
      foreach (cal[i]) cal[i] = '0;
      pending = 0;
    end else begin
      if (out_strobe) begin
        if (reading_q.size() == 0) begin
          fail_count++;
          $display("%0t: result beat with nothing expected: temp %0d pres %0d",
                   $time, out_temperature_centi, out_pressure_mbar);
        end else begin
          want = reading_q.pop_front();
          checked++;
          if (out_temperature_centi !== want.temp) begin
            fail_count++;
            $display("%0t: temperature_centi expected %0d got %0d",
                     $time, want.temp, out_temperature_centi);
          end
          if (out_pressure_mbar !== want.pres) begin
            fail_count++;
            $display("%0t: pressure_mbar expected %0d got %0d",
                     $time, want.pres, out_pressure_mbar);
          end
        end
      end
      if (start && !busy) begin
        want = compensate(in_raw_pressure, in_raw_temperature);
        cold_count += want.cold;
        reading_q.push_back(want);
      end
      if (cfg_we && cfg_index inside {[REG_C1:REG_C6]})
        cal[cfg_index] = cfg_wdata;
      pending = reading_q.size();
    end
  end

endmodule

/* test/tb.sv */
`timescale 1ns / 100ps
module tb;
  import ptsoc_pkg::*;

  localparam int               NUM_CAL     = REG_C6 + 1;
  localparam int               PHASE_BEATS = 220;
  localparam int               CYCLE_LIMIT = 100000;
  localparam logic [RAW_W-1:0] RAW_MAX     = '1;

  logic                     clk = 1'b0;
  logic                     rst_n;
  logic                     start;
  logic                     busy;
  logic [RAW_W-1:0]         in_raw_pressure;
  logic [RAW_W-1:0]         in_raw_temperature;
  logic                     out_strobe;
  logic signed [TEMP_W-1:0] out_temperature_centi;
  logic signed [PRES_W-1:0] out_pressure_mbar;
  logic                     cfg_we;
  logic [CFG_IDX_W-1:0]     cfg_index;
  logic [CAL_W-1:0]         cfg_wdata;

  int               cycles = 0;
  int               fail_count;
  int               pending;
  int               checked;
  int               cold_count;
  int               sets_loaded;
  logic [CAL_W-1:0] cal_set [NUM_CAL];

  pressure_temp_second_order_comp dut (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .start                 (start),
    .busy                  (busy),
    .in_raw_pressure       (in_raw_pressure),
    .in_raw_temperature    (in_raw_temperature),
    .out_strobe            (out_strobe),
    .out_temperature_centi (out_temperature_centi),
    .out_pressure_mbar     (out_pressure_mbar),
    .cfg_we                (cfg_we),
    .cfg_index             (cfg_index),
    .cfg_wdata             (cfg_wdata)
  );

  ptsoc_checker chk (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .start                 (start),
    .busy                  (busy),
    .in_raw_pressure       (in_raw_pressure),
    .in_raw_temperature    (in_raw_temperature),
    .out_strobe            (out_strobe),
    .out_temperature_centi (out_temperature_centi),
    .out_pressure_mbar     (out_pressure_mbar),
    .cfg_we                (cfg_we),
    .cfg_index             (cfg_index),
    .cfg_wdata             (cfg_wdata),
    .fail_count            (fail_count),
    .pending               (pending),
    .checked               (checked),
    .cold_count            (cold_count)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("[pressure_temp_second_order_comp] ERROR");
      $finish;
    end
  end

  task automatic send(input logic [RAW_W-1:0] d1, input logic [RAW_W-1:0] d2);
    logic ok;
    in_raw_pressure    <= d1;
    in_raw_temperature <= d2;
    start              <= 1'b1;
    do begin
      @(negedge clk);
      ok = !busy;
      @(posedge clk);
    end while (!ok);
  endtask

  task automatic pause(input int n);
    start <= 1'b0;
    repeat (n) @(posedge clk);
  endtask

  task automatic drain();
    start <= 1'b0;
    do @(negedge clk); while (pending != 0);
    @(posedge clk);
  endtask

  // write every word, then one write to an unmapped index
  task automatic load_cal();
    ptsoc_reg_t r;
    r = r.first();
    repeat (r.num()) begin
      cfg_we    <= 1'b1;
      cfg_index <= r;
      cfg_wdata <= cal_set[r];
      @(posedge clk);
      r = r.next();
    end
    cfg_index <= CFG_IDX_W'($urandom_range(NUM_CAL, 2**CFG_IDX_W - 1));
    cfg_wdata <= CAL_W'($urandom);
    @(posedge clk);
    cfg_we <= 1'b0;
    sets_loaded++;
  endtask

  task automatic run_random(input int beats, input bit steady);
    int               center;
    int               offset;
    int               d2;
    logic [RAW_W-1:0] d1;
    center = int'(cal_set[REG_C5]) * 256;
    repeat (beats) begin
      case ($urandom_range(0, 7))
        0: d1 = '0;
        1: d1 = RAW_MAX;
        default: d1 = RAW_W'($urandom);
      endcase
      if ($urandom_range(0, 1)) begin
        d2 = $urandom_range(0, RAW_MAX);
      end else begin
        // cluster around the reference temperature to hit both branches
        offset = $urandom_range(0, 1 << $urandom_range(0, 22));
        if ($urandom_range(0, 1)) offset = -offset;
        d2 = center + offset;
        if (d2 < 0) d2 = 0;
        if (d2 > int'(RAW_MAX)) d2 = RAW_MAX;
      end
      send(d1, RAW_W'(d2));
      if (!steady && $urandom_range(0, 3) == 0) pause($urandom_range(1, 4));
    end
  endtask

  initial begin
    int center;
    int cold_step;
    rst_n              = 1'b0;
    start              = 1'b0;
    in_raw_pressure    = '0;
    in_raw_temperature = '0;
    cfg_we             = 1'b0;
    cfg_index          = '0;
    cfg_wdata          = '0;
    sets_loaded        = 0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    cal_set = '{16'd34982, 16'd36352, 16'd20328, 16'd22354, 16'd26646, 16'd26146};
    load_cal();
    center    = int'(cal_set[REG_C5]) * 256;
    cold_step = ((1 << 23) + int'(cal_set[REG_C6]) - 1) / int'(cal_set[REG_C6]);
    send('0, RAW_W'(center));
    send(RAW_MAX, RAW_W'(center));
    send(RAW_MAX, RAW_W'(center - 1));
    pause(2);
    send(24'h800000, RAW_W'(center + 1));
    send(RAW_MAX, RAW_W'(center - cold_step));
    send(RAW_MAX, RAW_W'(center - cold_step + 1));
    send(24'hAAAAAA, 24'h555555);
    send(24'h555555, 24'hAAAAAA);
    send('0, '0);
    send(RAW_MAX, '0);
    send('0, RAW_MAX);
    send(RAW_MAX, RAW_MAX);

    drain();
    cal_set = '{default: '0};
    load_cal();
    send(RAW_MAX, RAW_MAX);
    send('0, '0);
    send(RAW_MAX, '0);

    drain();
    cal_set = '{default: '1};
    load_cal();
    send(RAW_MAX, RAW_MAX);
    send('0, '0);
    send(RAW_MAX, '0);
    send(RAW_MAX, 24'hFFFEFF);
    send('0, 24'hFFFF00);

    for (int p = 0; p < 8; p++) begin
      drain();
      case (p)
        0: cal_set = '{16'd34982, 16'd36352, 16'd20328, 16'd22354, 16'd26646, 16'd26146};
        1: cal_set = '{default: '0};
        2: cal_set = '{default: '1};
        3: cal_set = '{16'hFFFF, 16'h0000, 16'hFFFF, 16'h0000, 16'hFFFF, 16'hFFFF};
        4: cal_set = '{16'h0000, 16'hFFFF, 16'h0000, 16'hFFFF, 16'h0000, 16'hFFFF};
        default: foreach (cal_set[i]) cal_set[i] = CAL_W'($urandom);
      endcase
      load_cal();
      run_random(PHASE_BEATS, p == 7);
    end

    drain();
    repeat (LATENCY + 4) @(posedge clk);
    $display("checked %0d result beats (%0d cold branch) over %0d calibration sets,",
             checked, cold_count, sets_loaded);
    $display("including all-zero, all-one and mixed extreme words and unmapped writes");
    if (fail_count == 0 && pending == 0) begin
      $display("[pressure_temp_second_order_comp] OK");
    end else begin
      $display("[pressure_temp_second_order_comp] ERROR");
    end
    $finish;
  end

endmodule
